>>> hdl/pau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pau_pkg;

	localparam int POS_W = 48;
	localparam int NRM_W = 32;
	localparam int UNIT_W = 32;
	localparam int ANG_W = 24;
	localparam int NORM_W = 31;
	localparam int ANGLE_FRAC_BITS = 16;

	localparam int SQRT_STEPS = 32;
	localparam int SQRT_PER_ST = 2;
	localparam int SQRT_ST = SQRT_STEPS / SQRT_PER_ST;

	localparam int DIV_BITS = 32;
	localparam int DIV_PER_ST = 2;
	localparam int DIV_ST = DIV_BITS / DIV_PER_ST;

	localparam int CORDIC_STEPS = 31;
	localparam int CORDIC_PER_ST = 4;
	localparam int CORDIC_ST = (CORDIC_STEPS + CORDIC_PER_ST - 1) / CORDIC_PER_ST;

	localparam int UV_LAT = 4 + SQRT_ST + DIV_ST + 1;
	localparam int COS_LAT = 2;
	localparam int ACOS_LAT = 1 + SQRT_ST + CORDIC_ST + 3;
	localparam int TOTAL_LAT = UV_LAT + COS_LAT + ACOS_LAT;

	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic [31:0] RAD_TO_DEG_Q26 = 32'd3845054675;
	localparam logic [64:0] DEG_TOP = 65'd180 << ANGLE_FRAC_BITS;

	localparam logic [31:0] ATAN_ROM [10] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
		32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149
	};

	typedef struct packed {
		logic signed [POS_W-1:0] point_x;
		logic signed [POS_W-1:0] point_y;
		logic signed [POS_W-1:0] point_z;
		logic signed [NRM_W-1:0] normal_x;
		logic signed [NRM_W-1:0] normal_y;
		logic signed [NRM_W-1:0] normal_z;
		logic signed [POS_W-1:0] observer_x;
		logic signed [POS_W-1:0] observer_y;
		logic signed [POS_W-1:0] observer_z;
		logic signed [POS_W-1:0] illum_x;
		logic signed [POS_W-1:0] illum_y;
		logic signed [POS_W-1:0] illum_z;
	} item_t;

	typedef struct packed {
		logic [ANG_W-1:0] emission_angle;
		logic [ANG_W-1:0] incidence_angle;
		logic [ANG_W-1:0] phase_angle;
	} result_t;

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] root;
	} sqrt_t;

	// one digit of the bit-pair integer square root
	function automatic sqrt_t sqrt_step(sqrt_t a, int k);
		logic [63:0] b;
		logic [64:0] t;
		sqrt_t o;
		b = 64'd1 << (62 - 2 * k);
		t = {1'b0, a.root} + {1'b0, b};
		if ({1'b0, a.rem} >= t) begin
			o.rem = a.rem - t[63:0];
			o.root = (a.root >> 1) + b;
		end else begin
			o.rem = a.rem;
			o.root = a.root >> 1;
		end
		return o;
	endfunction

	function automatic logic signed [33:0] atan_step(int i);
		logic signed [33:0] v;
		if (i < 10) begin
			v = $signed({2'b00, ATAN_ROM[i]});
		end else begin
			v = 34'sd1 <<< (30 - i);
		end
		return v;
	endfunction

endpackage
`default_nettype wire

>>> hdl/pau_unit_vec.sv
`timescale 1ns / 1ps
`default_nettype none
module pau_unit_vec import pau_pkg::*; (
	input  logic                          clk,
	input  logic                          en,
	input  logic [2:0][POS_W-1:0]         tgt,
	input  logic [2:0][POS_W-1:0]         org,
	output logic [2:0][UNIT_W-1:0]        u
);

	typedef struct packed {
		sqrt_t                  sq;
		logic [2:0][NORM_W-1:0] mag;
		logic [2:0]             neg;
		logic                   zero;
	} uv_sq_t;

	typedef struct packed {
		logic [2:0][63:0]         rem;
		logic [2:0][DIV_BITS-1:0] q;
		logic [31:0]              r;
		logic [2:0]               neg;
		logic                     zero;
	} uv_div_t;

	logic [2:0][POS_W-1:0]  mag_d;
	logic [2:0]             neg_d;
	logic [2:0][POS_W-1:0]  mag_s1;
	logic [2:0]             neg_s1;
	logic [2:0][NORM_W-1:0] norm_d;
	logic                   zero_d;
	logic [2:0][NORM_W-1:0] norm_s2, norm_s3, norm_s4;
	logic [2:0]             neg_s2, neg_s3, neg_s4;
	logic                   zero_s2, zero_s3, zero_s4;
	logic [2:0][61:0]       sq_s3;
	logic [63:0]            sum_s4;
	uv_sq_t                 sq_nxt [SQRT_ST];
	uv_sq_t                 sq_s [SQRT_ST];
	uv_div_t                dv_nxt [DIV_ST];
	uv_div_t                dv_s [DIV_ST];

	always_comb begin
		logic signed [POS_W:0] d;
		logic [POS_W:0] dm;
		for (int j = 0; j < 3; j++) begin
			d = $signed({tgt[j][POS_W-1], tgt[j]}) - $signed({org[j][POS_W-1], org[j]});
			dm = d[POS_W] ? (POS_W+1)'(-d) : (POS_W+1)'(d);
			neg_d[j] = d[POS_W];
			mag_d[j] = dm[POS_W-1:0];
		end
	end

	// scale so the largest magnitude lands in [2^30, 2^31)
	always_comb begin
		logic [POS_W-1:0] m;
		logic [5:0] len;
		logic [POS_W-1:0] t;
		m = '0;
		for (int j = 0; j < 3; j++) begin
			if (mag_s1[j] > m) begin
				m = mag_s1[j];
			end
		end
		len = '0;
		for (int b = 0; b < POS_W; b++) begin
			if (m[b]) begin
				len = 6'(b + 1);
			end
		end
		for (int j = 0; j < 3; j++) begin
			if (len > 6'd31) begin
				t = mag_s1[j] >> (len - 6'd31);
			end else begin
				t = mag_s1[j] << (6'd31 - len);
			end
			norm_d[j] = t[NORM_W-1:0];
		end
		zero_d = (m == '0);
	end

	always_comb begin
		uv_sq_t cur;
		for (int s = 0; s < SQRT_ST; s++) begin
			if (s == 0) begin
				cur.sq.rem = sum_s4;
				cur.sq.root = '0;
				cur.mag = norm_s4;
				cur.neg = neg_s4;
				cur.zero = zero_s4;
			end else begin
				cur = sq_s[s-1];
			end
			for (int k = 0; k < SQRT_PER_ST; k++) begin
				cur.sq = sqrt_step(cur.sq, s * SQRT_PER_ST + k);
			end
			sq_nxt[s] = cur;
		end
	end

	// restoring division, one quotient bit per step
	always_comb begin
		uv_div_t cur;
		logic [63:0] dd;
		int kb;
		for (int s = 0; s < DIV_ST; s++) begin
			if (s == 0) begin
				cur.r = sq_s[SQRT_ST-1].sq.root[31:0];
				for (int j = 0; j < 3; j++) begin
					cur.rem[j] = {3'b000, sq_s[SQRT_ST-1].mag[j], 30'd0}
						+ {33'd0, sq_s[SQRT_ST-1].sq.root[31:1]};
				end
				cur.q = '0;
				cur.neg = sq_s[SQRT_ST-1].neg;
				cur.zero = sq_s[SQRT_ST-1].zero;
			end else begin
				cur = dv_s[s-1];
			end
			for (int k = 0; k < DIV_PER_ST; k++) begin
				kb = DIV_BITS - 1 - (s * DIV_PER_ST + k);
				dd = {32'd0, cur.r} << kb;
				for (int j = 0; j < 3; j++) begin
					if (cur.rem[j] >= dd) begin
						cur.rem[j] = cur.rem[j] - dd;
						cur.q[j][kb] = 1'b1;
					end
				end
			end
			dv_nxt[s] = cur;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_d;
			neg_s1 <= neg_d;
			norm_s2 <= norm_d;
			neg_s2 <= neg_s1;
			zero_s2 <= zero_d;
			for (int j = 0; j < 3; j++) begin
				sq_s3[j] <= 62'(norm_s2[j]) * 62'(norm_s2[j]);
			end
			norm_s3 <= norm_s2;
			neg_s3 <= neg_s2;
			zero_s3 <= zero_s2;
			sum_s4 <= 64'(sq_s3[0]) + 64'(sq_s3[1]) + 64'(sq_s3[2]);
			norm_s4 <= norm_s3;
			neg_s4 <= neg_s3;
			zero_s4 <= zero_s3;
			sq_s <= sq_nxt;
			dv_s <= dv_nxt;
			for (int j = 0; j < 3; j++) begin
				if (dv_s[DIV_ST-1].zero) begin
					u[j] <= '0;
				end else if (dv_s[DIV_ST-1].neg[j]) begin
					u[j] <= -dv_s[DIV_ST-1].q[j];
				end else begin
					u[j] <= dv_s[DIV_ST-1].q[j];
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/pau_arccos.sv
`timescale 1ns / 1ps
`default_nettype none
module pau_arccos import pau_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [31:0]      c,
	output logic [ANG_W-1:0]        angle
);

	typedef struct packed {
		sqrt_t              sq;
		logic signed [31:0] c;
	} ac_sq_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
		logic               base;
	} cd_t;

	logic signed [63:0] csq_d;
	logic [63:0]        csq_s1;
	logic signed [31:0] c_s1;
	ac_sq_t             sq_nxt [SQRT_ST];
	ac_sq_t             sq_s [SQRT_ST];
	cd_t                cd_nxt [CORDIC_ST];
	cd_t                cd_s [CORDIC_ST];
	logic [31:0]        tot_d;
	logic [64:0]        ang_d;
	// stages after the cordic
	logic [31:0]        tot_s1;
	logic [63:0]        prod_s2;

	always_comb begin
		csq_d = c * c;
	end

	always_comb begin
		ac_sq_t cur;
		for (int s = 0; s < SQRT_ST; s++) begin
			if (s == 0) begin
				cur.sq.rem = (64'd1 << 60) - csq_s1;
				cur.sq.root = '0;
				cur.c = c_s1;
			end else begin
				cur = sq_s[s-1];
			end
			for (int k = 0; k < SQRT_PER_ST; k++) begin
				cur.sq = sqrt_step(cur.sq, s * SQRT_PER_ST + k);
			end
			sq_nxt[s] = cur;
		end
	end

	// vectoring cordic, turned by -90 degrees first when the cosine is not positive
	always_comb begin
		cd_t cur;
		logic signed [33:0] sv, cv, dx, dy;
		int i;
		for (int s = 0; s < CORDIC_ST; s++) begin
			if (s == 0) begin
				sv = $signed({2'b00, sq_s[SQRT_ST-1].sq.root[31:0]});
				cv = 34'(sq_s[SQRT_ST-1].c);
				if (cv <= 0) begin
					cur.x = sv;
					cur.y = -cv;
					cur.base = 1'b1;
				end else begin
					cur.x = cv;
					cur.y = sv;
					cur.base = 1'b0;
				end
				cur.z = '0;
			end else begin
				cur = cd_s[s-1];
			end
			for (int k = 0; k < CORDIC_PER_ST; k++) begin
				i = s * CORDIC_PER_ST + k;
				if (i < CORDIC_STEPS) begin
					dx = cur.y >>> i;
					dy = cur.x >>> i;
					if (cur.y > 0) begin
						cur.x = cur.x + dx;
						cur.y = cur.y - dy;
						cur.z = cur.z + atan_step(i);
					end else begin
						cur.x = cur.x - dx;
						cur.y = cur.y + dy;
						cur.z = cur.z - atan_step(i);
					end
				end
			end
			cd_nxt[s] = cur;
		end
	end

	always_comb begin
		logic signed [34:0] tsum;
		if (cd_s[CORDIC_ST-1].base) begin
			tsum = $signed({3'b000, HALF_PI_Q30}) + 35'(cd_s[CORDIC_ST-1].z);
		end else begin
			tsum = 35'(cd_s[CORDIC_ST-1].z);
		end
		if (tsum < 0) begin
			tot_d = '0;
		end else if (tsum > $signed({3'b000, PI_Q30})) begin
			tot_d = PI_Q30;
		end else begin
			tot_d = tsum[31:0];
		end
	end

	always_comb begin
		logic [64:0] sum;
		sum = {1'b0, prod_s2} + (65'd1 << (55 - ANGLE_FRAC_BITS));
		ang_d = sum >> (56 - ANGLE_FRAC_BITS);
		if (ang_d > DEG_TOP) begin
			ang_d = DEG_TOP;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			csq_s1 <= $unsigned(csq_d);
			c_s1 <= c;
			sq_s <= sq_nxt;
			cd_s <= cd_nxt;
			tot_s1 <= tot_d;
			prod_s2 <= 64'(tot_s1) * 64'(RAD_TO_DEG_Q26);
			angle <= ang_d[ANG_W-1:0];
		end
	end

endmodule
`default_nettype wire

>>> hdl/photometric_angle_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// item transfer to result valid passes unit vectors, then cosines, then arccos
// throughput: one item per cycle while no result is stalled; depth set by the 16-stage
// square roots, the 16-stage restoring dividers and the 8-stage cordic
// a stalled result holds the whole pipeline, item_stall follows it
// reset clears only the valid bits; data registers are not reset
module photometric_angle_unit import pau_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic                         en;
	logic [TOTAL_LAT-1:0]         vld_q;
	logic [2:0][NRM_W-1:0]        nrm_q [UV_LAT];
	logic [2:0][POS_W-1:0]        pt, obs, ill;
	logic [2:0][UNIT_W-1:0]       uo, ui;
	logic signed [8:0][63:0]      prod_s1;
	logic signed [2:0][31:0]      cos_d;
	logic signed [31:0]           cos_s2 [3];
	logic [ANG_W-1:0]             ang [3];

	assign en = !(vld_q[TOTAL_LAT-1] && result_stall);
	assign item_stall = !en;
	assign result_valid = vld_q[TOTAL_LAT-1];

	assign pt = {item.point_z, item.point_y, item.point_x};
	assign obs = {item.observer_z, item.observer_y, item.observer_x};
	assign ill = {item.illum_z, item.illum_y, item.illum_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], item_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nrm_q[0] <= {item.normal_z, item.normal_y, item.normal_x};
			for (int k = 1; k < UV_LAT; k++) begin
				nrm_q[k] <= nrm_q[k-1];
			end
		end
	end

	pau_unit_vec u_uv_obs (
		.clk (clk),
		.en  (en),
		.tgt (obs),
		.org (pt),
		.u   (uo)
	);

	pau_unit_vec u_uv_ill (
		.clk (clk),
		.en  (en),
		.tgt (ill),
		.org (pt),
		.u   (ui)
	);

	// products: 0..2 emission, 3..5 incidence, 6..8 phase
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				prod_s1[j] <= $signed(nrm_q[UV_LAT-1][j]) * $signed(uo[j]);
				prod_s1[3+j] <= $signed(nrm_q[UV_LAT-1][j]) * $signed(ui[j]);
				prod_s1[6+j] <= $signed(uo[j]) * $signed(ui[j]);
			end
		end
	end

	// round half away from zero to q30, clamp to unit
	always_comb begin
		logic signed [65:0] s;
		logic [65:0] m, r;
		for (int a = 0; a < 3; a++) begin
			s = 66'($signed(prod_s1[3*a])) + 66'($signed(prod_s1[3*a+1]))
				+ 66'($signed(prod_s1[3*a+2]));
			m = s[65] ? 66'(-s) : 66'(s);
			r = (m + (66'd1 << 29)) >> 30;
			if (r > (66'd1 << 30)) begin
				r = 66'd1 << 30;
			end
			cos_d[a] = s[65] ? -r[31:0] : r[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				cos_s2[a] <= cos_d[a];
			end
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_acos
		pau_arccos u_acos (
			.clk   (clk),
			.en    (en),
			.c     (cos_s2[a]),
			.angle (ang[a])
		);
	end

	assign result.emission_angle = ang[0];
	assign result.incidence_angle = ang[1];
	assign result.phase_angle = ang[2];

`ifndef ASSERT_OFF
	a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("item side stalled without a held result");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ({1'b0, result.emission_angle} <= DEG_TOP[ANG_W:0]
			&& {1'b0, result.incidence_angle} <= DEG_TOP[ANG_W:0]
			&& {1'b0, result.phase_angle} <= DEG_TOP[ANG_W:0]))
		else $error("angle beyond 180 degrees");

	a_valid_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_q[TOTAL_LAT-2]) |=> result_valid)
		else $error("valid bit lost in pipeline");
`endif

endmodule
`default_nettype wire

>>> bench/pau_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module pau_checker import pau_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_stall,
	input  item_t   item,
	input  logic    result_valid,
	input  logic    result_stall,
	input  result_t result,
	output int      fail_count,
	output int      pending,
	output int      checked
);

	typedef struct packed {
		longint x;
		longint y;
		longint z;
	} vec_t;

	localparam longint ARC_TAB [10] = '{
		843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149
	};
	localparam longint HALF_PI = 64'd1686629713;
	localparam longint FULL_PI = 64'd3373259426;
	localparam longint unsigned DEG_PER_RAD = 64'd3845054675;

	result_t angles_due [$];

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// direction from point to target, normalized to q30
	function automatic vec_t unit_dir(vec_t tgt, vec_t from);
		longint t [3];
		longint f [3];
		longint u [3];
		longint unsigned mag [3];
		bit neg [3];
		longint d;
		longint unsigned m, s, r, q;
		int len;
		vec_t o;
		t = '{tgt.x, tgt.y, tgt.z};
		f = '{from.x, from.y, from.z};
		m = 0;
		s = 0;
		len = 0;
		for (int j = 0; j < 3; j++) begin
			d = t[j] - f[j];
			neg[j] = d < 0;
			mag[j] = neg[j] ? -d : d;
			if (mag[j] > m) m = mag[j];
		end
		if (m == 0) begin
			o = '0;
			return o;
		end
		while (len < 63 && (m >> len) != 0) len++;
		for (int j = 0; j < 3; j++) begin
			if (len > 31) mag[j] = mag[j] >> (len - 31);
			else mag[j] = mag[j] << (31 - len);
			s += mag[j] * mag[j];
		end
		r = int_sqrt(s);
		for (int j = 0; j < 3; j++) begin
			q = ((mag[j] << 30) + (r >> 1)) / r;
			u[j] = neg[j] ? -longint'(q) : longint'(q);
		end
		o.x = u[0];
		o.y = u[1];
		o.z = u[2];
		return o;
	endfunction

	function automatic longint dot_q30(vec_t a, vec_t b);
		longint s;
		longint unsigned mag;
		bit neg;
		s = a.x * b.x + a.y * b.y + a.z * b.z;
		neg = s < 0;
		mag = neg ? -s : s;
		mag = (mag + (64'd1 << 29)) >> 30;
		if (mag > (64'd1 << 30)) mag = 64'd1 << 30;
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic logic [ANG_W-1:0] acos_deg(longint c);
		longint x, y, z, base, total, dx, dy, t;
		longint unsigned deg, top;
		x = c;
		z = 0;
		base = 0;
		y = int_sqrt((64'd1 << 60) - longint'(c * c));
		if (x <= 0) begin
			t = x;
			x = y;
			y = -t;
			base = HALF_PI;
		end
		for (int i = 0; i < 31; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx;
				y -= dy;
				z += (i < 10) ? ARC_TAB[i] : (64'sd1 <<< (30 - i));
			end else begin
				x -= dx;
				y += dy;
				z -= (i < 10) ? ARC_TAB[i] : (64'sd1 <<< (30 - i));
			end
		end
		total = base + z;
		if (total < 0) total = 0;
		if (total > FULL_PI) total = FULL_PI;
		deg = (longint'(total) * DEG_PER_RAD + (64'd1 << (55 - ANGLE_FRAC_BITS)))
			>> (56 - ANGLE_FRAC_BITS);
		top = 64'd180 << ANGLE_FRAC_BITS;
		if (deg > top) deg = top;
		return deg[ANG_W-1:0];
	endfunction

	function automatic result_t photometric_angles(item_t it);
		vec_t pt, nrm, obs, ill, uo, ui;
		result_t r;
		pt = '{longint'(it.point_x), longint'(it.point_y), longint'(it.point_z)};
		nrm = '{longint'(it.normal_x), longint'(it.normal_y), longint'(it.normal_z)};
		obs = '{longint'(it.observer_x), longint'(it.observer_y), longint'(it.observer_z)};
		ill = '{longint'(it.illum_x), longint'(it.illum_y), longint'(it.illum_z)};
		uo = unit_dir(obs, pt);
		ui = unit_dir(ill, pt);
		r.emission_angle = acos_deg(dot_q30(nrm, uo));
		r.incidence_angle = acos_deg(dot_q30(nrm, ui));
		r.phase_angle = acos_deg(dot_q30(uo, ui));
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [ANG_W-1:0] got, logic [ANG_W-1:0] want);
		$display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
		fail_count++;
	endtask

	assign pending = angles_due.size();

	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			fail_count = 0;
			checked = 0;
			angles_due.delete();
		end else begin
			if (item_valid && !item_stall) angles_due.push_back(photometric_angles(item));
			if (result_valid && !result_stall) begin
				if (angles_due.size() == 0) begin
					$display("%0t result transfer with nothing outstanding", $time);
					fail_count++;
				end else begin
					want = angles_due.pop_front();
					checked++;
					if (result.emission_angle !== want.emission_angle)
						report_mismatch("emission", result.emission_angle, want.emission_angle);
					if (result.incidence_angle !== want.incidence_angle)
						report_mismatch("incidence", result.incidence_angle, want.incidence_angle);
					if (result.phase_angle !== want.phase_angle)
						report_mismatch("phase", result.phase_angle, want.phase_angle);
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import pau_pkg::*;

	localparam int RANDOM_ITEMS = 850;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_START = 600;
	localparam int HOLD_LEN = 300;
	localparam logic signed [NRM_W-1:0] ONE = 32'sd1073741824;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;
	int      fail_count;
	int      pending;
	int      checked;
	int      cycle = 0;
	int      sent;

	photometric_angle_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	pau_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.fail_count(fail_count), .pending(pending), .checked(checked)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", pending);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: rotating stall patterns plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall = 1'b0;
		end else if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_LEN) begin
			result_stall = 1'b1;
		end else begin
			case ((cycle / 64) % 4)
				0: result_stall = 1'b0;
				1: result_stall = ($urandom_range(1) == 0);
				2: result_stall = (cycle % 4 != 0);
				default: result_stall = ($urandom_range(4) == 0);
			endcase
		end
	end

	function automatic logic signed [POS_W-1:0] rnd_pos();
		return POS_W'({$urandom(), $urandom()});
	endfunction

	// positions in [-2^33, 2^33), or any bit pattern
	function automatic logic signed [POS_W-1:0] pick_pos(bit wild);
		logic signed [POS_W-1:0] v;
		if (wild) v = rnd_pos();
		else v = POS_W'($signed({$urandom_range(3), $urandom()}) - (48'sd1 << 33));
		return v;
	endfunction

	function automatic logic signed [NRM_W-1:0] pick_nrm(bit wild);
		logic signed [NRM_W-1:0] v;
		case ($urandom_range(3))
			0: v = $urandom();
			1: v = $urandom_range(1) ? ONE : -ONE;
			default: v = $signed($urandom_range(32'h7fffffff)) - (32'sd1 << 30);
		endcase
		if (!wild && v > ONE) v = ONE;
		return v;
	endfunction

	task automatic send(item_t v);
		item = v;
		item_valid = 1'b1;
		do @(posedge clk); while (item_stall);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_gap(item_t v, int gap);
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		send(v);
	endtask

	function automatic item_t make_item(logic signed [POS_W-1:0] p, logic signed [NRM_W-1:0] nx,
			logic signed [NRM_W-1:0] ny, logic signed [NRM_W-1:0] nz,
			logic signed [POS_W-1:0] ox, logic signed [POS_W-1:0] oy,
			logic signed [POS_W-1:0] ix, logic signed [POS_W-1:0] iz);
		item_t v;
		v = '0;
		v.point_x = p; v.point_y = p; v.point_z = p;
		v.normal_x = nx; v.normal_y = ny; v.normal_z = nz;
		v.observer_x = ox; v.observer_y = oy; v.observer_z = p;
		v.illum_x = ix; v.illum_y = p; v.illum_z = iz;
		return v;
	endfunction

	function automatic item_t random_item();
		item_t v;
		bit wild;
		wild = ($urandom_range(4) == 0);
		v.point_x = pick_pos(wild); v.point_y = pick_pos(wild); v.point_z = pick_pos(wild);
		v.normal_x = pick_nrm(wild); v.normal_y = pick_nrm(wild); v.normal_z = pick_nrm(wild);
		v.observer_x = pick_pos(wild); v.observer_y = pick_pos(wild);
		v.observer_z = pick_pos(wild);
		v.illum_x = pick_pos(wild); v.illum_y = pick_pos(wild); v.illum_z = pick_pos(wild);
		case ($urandom_range(15))
			0: {v.observer_x, v.observer_y, v.observer_z} = {v.point_x, v.point_y, v.point_z};
			1: {v.illum_x, v.illum_y, v.illum_z} = {v.point_x, v.point_y, v.point_z};
			2: {v.illum_x, v.illum_y, v.illum_z} =
				{v.observer_x, v.observer_y, v.observer_z};
			3: v.observer_x = v.point_x + $signed({1'b0, $urandom_range(3)});
			default: ;
		endcase
		return v;
	endfunction

	initial begin
		item_t v;
		int burst;
		int gap;
		sent = 0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// all zero: both directions degenerate
		send('0);
		// normal along z with both directions degenerate, then observer straight up the normal, illuminator straight down
		send(make_item(48'sd0, 32'sd0, 32'sd0, ONE, 48'sd0, 48'sd0, 48'sd0, 48'sd0));
		v = '0; v.normal_z = ONE; v.observer_z = 48'sd65536; v.illum_z = -48'sd65536;
		send(v);
		v.illum_z = 48'sd0; v.illum_x = 48'sd65536;
		send(v);
		v.normal_z = -ONE; v.observer_x = 48'sd1; v.illum_y = -48'sd1;
		send(v);
		// extreme positions
		v = '0;
		v.point_x = {1'b1, 47'd0}; v.point_y = {1'b1, 47'd0}; v.point_z = {1'b1, 47'd0};
		v.observer_x = {1'b0, {47{1'b1}}}; v.observer_y = {1'b0, {47{1'b1}}};
		v.observer_z = {1'b0, {47{1'b1}}};
		v.illum_x = {1'b0, {47{1'b1}}}; v.illum_y = {1'b1, 47'd0};
		v.illum_z = {1'b0, {47{1'b1}}};
		v.normal_x = ONE;
		send(v);
		v.point_x = {1'b0, {47{1'b1}}}; v.observer_x = {1'b1, 47'd0};
		v.normal_x = 32'h7fffffff; v.normal_y = 32'h80000000; v.normal_z = 32'h7fffffff;
		send(v);
		// normal outside unit range, then a tiny normal; observer and illuminator in the same direction
		v = '0; v.normal_x = 32'h80000000; v.normal_y = 32'h80000000; v.normal_z = 32'h80000000;
		v.observer_x = -48'sd5; v.illum_x = -48'sd5; v.observer_y = -48'sd7; v.illum_y = -48'sd7;
		send(v);
		v.normal_x = 32'hffffffff; v.normal_y = 32'h00000001; v.normal_z = 32'h0;
		send(v);
		// point equal to observer, then to illuminator
		v = make_item(48'sd123456789, ONE, 32'sd0, 32'sd0, 48'sd123456789, 48'sd123456789,
			48'sd0, 48'sd0);
		send(v);
		v = make_item(-48'sd9876543, 32'sd0, -ONE, 32'sd0, 48'sd0, 48'sd1,
			-48'sd9876543, -48'sd9876543);
		send(v);
		// tiny offsets and a near-grazing geometry
		v = '0; v.normal_z = ONE; v.observer_x = 48'sd1 <<< 40; v.observer_z = 48'sd1;
		v.illum_x = -(48'sd1 <<< 40); v.illum_z = -48'sd1;
		send(v);
		v.observer_z = 48'sd3; v.illum_y = 48'sd1;
		send(v);
		for (int k = 0; k < 6; k++) send(random_item());

		// let everything drain before the random part
		item_valid = 1'b0;
		wait (pending == 0);
		@(negedge clk);

		burst = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			gap = 0;
			if (burst == 0) begin
				burst = $urandom_range(40, 1);
				gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
			end
			burst--;
			if (n == RANDOM_ITEMS / 2) begin
				item_valid = 1'b0;
				wait (pending == 0);
				@(negedge clk);
			end
			send_gap(random_item(), gap);
		end
		item_valid = 1'b0;

		wait (pending == 0);
		repeat (TOTAL_LAT + 20) @(negedge clk);
		$display("sent %0d items (directed extremes, degenerate and random geometry)", sent);
		$display("checked %0d results under bursty input and patterned output stalls", checked);
		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
`default_nettype wire
